// File: rtl/fmbq_pkg.sv
// Shared types and constants for the front/middle/back queue.
`timescale 1ns / 1ps
`default_nettype none

package fmbq_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OP_W     = 3;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 2;
  localparam int OCC_W    = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT  = 3'd0,
    OP_PUSH_MIDDLE = 3'd1,
    OP_PUSH_BACK   = 3'd2,
    OP_POP_FRONT   = 3'd3,
    OP_POP_MIDDLE  = 3'd4,
    OP_POP_BACK    = 3'd5
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the incoming request
    logic execute;  // apply the latched request, load the result register
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/fmbq_datapath.sv
// Queue storage, shift network, request latch and result register.
`timescale 1ns / 1ps
`default_nettype none

module fmbq_datapath (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire fmbq_pkg::cmd_t                  cmd_i,
  input  wire logic [fmbq_pkg::OP_W-1:0]       op_i,
  input  wire logic signed [fmbq_pkg::VAL_W-1:0] push_value_i,
  output logic signed [fmbq_pkg::VAL_W-1:0]    pop_value_o,
  output logic [fmbq_pkg::STAT_W-1:0]          status_o,
  output logic [fmbq_pkg::OCC_W-1:0]           occupancy_o
);

  logic [fmbq_pkg::OP_W-1:0]         op_q;
  logic signed [fmbq_pkg::VAL_W-1:0] val_q;
  logic [fmbq_pkg::CNT_W-1:0]        count_q, count_d;
  logic signed [fmbq_pkg::VAL_W-1:0] entries_q [fmbq_pkg::CAPACITY];
  logic signed [fmbq_pkg::VAL_W-1:0] entries_d [fmbq_pkg::CAPACITY];

  logic signed [fmbq_pkg::VAL_W-1:0] res_value_q, res_value_d;
  logic [fmbq_pkg::STAT_W-1:0]       res_status_q, res_status_d;
  logic [fmbq_pkg::OCC_W-1:0]        res_occ_q;

  logic                       do_push, do_pop;
  logic [fmbq_pkg::CNT_W-1:0] pos;
  logic [fmbq_pkg::CNT_W-1:0] count_m1;
  logic                       full, empty;

  assign full     = (count_q == fmbq_pkg::CNT_W'(fmbq_pkg::CAPACITY));
  assign empty    = (count_q == '0);
  assign count_m1 = count_q - fmbq_pkg::CNT_W'(1);

  // Decode: where the change happens and whether it happens at all.
  always_comb begin
    do_push      = 1'b0;
    do_pop       = 1'b0;
    pos          = '0;
    res_value_d  = '0;
    res_status_d = fmbq_pkg::STAT_OK;
    unique case (op_q) inside
      fmbq_pkg::OP_PUSH_FRONT, fmbq_pkg::OP_PUSH_MIDDLE, fmbq_pkg::OP_PUSH_BACK: begin
        do_push = !full;
        if (full) res_status_d = fmbq_pkg::STAT_FULL;
        if (op_q == fmbq_pkg::OP_PUSH_MIDDLE)    pos = count_q >> 1;
        else if (op_q == fmbq_pkg::OP_PUSH_BACK) pos = count_q;
      end
      fmbq_pkg::OP_POP_FRONT, fmbq_pkg::OP_POP_MIDDLE, fmbq_pkg::OP_POP_BACK: begin
        do_pop = !empty;
        if (empty) begin
          res_value_d  = '1;
          res_status_d = fmbq_pkg::STAT_EMPTY;
        end
        if (op_q == fmbq_pkg::OP_POP_MIDDLE)    pos = count_m1 >> 1;
        else if (op_q == fmbq_pkg::OP_POP_BACK) pos = count_m1;
        if (!empty) res_value_d = entries_q[pos[fmbq_pkg::IDX_W-1:0]];
      end
      default: ;  // unused codes: no change
    endcase
  end

  // Per-entry select: hold, take left neighbor, take right neighbor, or new value.
  always_comb begin
    for (int i = 0; i < fmbq_pkg::CAPACITY; i++) begin
      entries_d[i] = entries_q[i];
      if (do_push) begin
        if (fmbq_pkg::CNT_W'(i) == pos)      entries_d[i] = val_q;
        else if (fmbq_pkg::CNT_W'(i) > pos)  entries_d[i] = entries_q[(i > 0) ? i - 1 : 0];
      end else if (do_pop) begin
        if (fmbq_pkg::CNT_W'(i) >= pos && i < fmbq_pkg::CAPACITY - 1)
          entries_d[i] = entries_q[i + 1];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_push)     count_d = count_q + fmbq_pkg::CNT_W'(1);
    else if (do_pop) count_d = count_m1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.execute) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_i;
      val_q <= push_value_i;
    end
    if (cmd_i.execute) begin
      for (int i = 0; i < fmbq_pkg::CAPACITY; i++) entries_q[i] <= entries_d[i];
      res_value_q  <= res_value_d;
      res_status_q <= res_status_d;
      res_occ_q    <= fmbq_pkg::OCC_W'(count_d);
    end
  end

  assign pop_value_o = res_value_q;
  assign status_o    = res_status_q;
  assign occupancy_o = res_occ_q;

endmodule

`default_nettype wire

// File: rtl/fmbq_ctrl.sv
// Controller state machine: request capture, execution and result valid.
`timescale 1ns / 1ps
`default_nettype none

module fmbq_ctrl (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  wire            out_stall_i,
  output fmbq_pkg::cmd_t cmd_o
);

  fmbq_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             res_free;

  // Result register can take a new result if empty or being drained now.
  assign res_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    unique case (state_q)
      fmbq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = fmbq_pkg::S_EXEC;
        end
      end
      fmbq_pkg::S_EXEC: begin
        if (res_free) begin
          cmd_o.execute = 1'b1;
          state_d       = fmbq_pkg::S_IDLE;
        end
      end
      default: state_d = fmbq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.execute)                   out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fmbq_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != fmbq_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: rtl/front_middle_back_queue_unit.sv
// Top level of the front/middle/back queue of signed 32-bit values.
//
// Input channel: in_valid_i / in_stall_o carry one request (op_i, push_value_i).
//   A request is taken at a rising edge with in_valid_i high and in_stall_o low.
//   op_i: push front/middle/back, pop front/middle/back; codes 6 and 7 are no-ops.
// Output channel: out_valid_o / out_stall_i carry one result per request:
//   pop_value_o (popped value, -1 on empty pop, 0 otherwise), status_o
//   (ok, pop on empty, push dropped on full) and occupancy_o after the request.
// Requests: a new request is not taken until the previous one is applied; the
//   controller latches a request, then applies it to the entry registers once
//   the result register is free, and the single request latch holds one request at a time.
// Storage: CAPACITY entry registers, each loading from its left neighbor,
//   its right neighbor, itself or the pushed value, so any operation is one
//   register update.
// Reset: count and handshake state clear; the entry registers are not reset.
// Stall: a result waits in the output register while out_stall_i is high; the
//   next request is still latched, and is applied once the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module front_middle_back_queue_unit (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [fmbq_pkg::OP_W-1:0]         op_i,
  input  wire logic signed [fmbq_pkg::VAL_W-1:0] push_value_i,
  output logic                                   out_valid_o,
  input  wire                                    out_stall_i,
  output logic signed [fmbq_pkg::VAL_W-1:0]      pop_value_o,
  output logic [fmbq_pkg::STAT_W-1:0]            status_o,
  output logic [fmbq_pkg::OCC_W-1:0]             occupancy_o
);

  fmbq_pkg::cmd_t cmd;

  // Sequencing: capture, then execute once the result register is free.
  fmbq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Entry registers, count and result register.
  fmbq_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .op_i         (op_i),
    .push_value_i (push_value_i),
    .pop_value_o  (pop_value_o),
    .status_o     (status_o),
    .occupancy_o  (occupancy_o)
  );

endmodule

`default_nettype wire

// File: dv/fmbq_checker.sv
// Scoreboard for the front/middle/back queue: predicts every result and compares it.
`timescale 1ns / 1ps

module fmbq_checker
  import fmbq_pkg::*;
(
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  input  wire                    in_stall_i,
  input  wire [OP_W-1:0]         op_i,
  input  wire signed [VAL_W-1:0] push_value_i,
  input  wire                    out_valid_i,
  input  wire                    out_stall_i,
  input  wire signed [VAL_W-1:0] pop_value_i,
  input  wire [STAT_W-1:0]       status_i,
  input  wire [OCC_W-1:0]        occupancy_i,
  output int                     fail_count_o,
  output int                     results_o,
  output int                     pending_o
);

  localparam int REPORT_CAP = 100;

  typedef struct {
    logic signed [VAL_W-1:0] pop_value;
    status_e                 status;
    logic [OCC_W-1:0]        occupancy;
  } queue_result_t;

  logic signed [VAL_W-1:0] entry_model[$];  // index 0 is the front
  queue_result_t           awaited_results[$];
  queue_result_t           oldest;
  int                      fail_count = 0;
  int                      results_seen = 0;
  int                      lines_printed = 0;

  // Applies one request to the queue model and returns the result it yields.
  function automatic queue_result_t queue_apply(input logic [OP_W-1:0] op,
                                                input logic signed [VAL_W-1:0] v);
    queue_result_t r;
    int            n;
    n           = entry_model.size();
    r.pop_value = '0;
    r.status    = STAT_OK;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_MIDDLE, OP_PUSH_BACK: begin
        if (n >= CAPACITY) begin
          r.status = STAT_FULL;
        end else if (op == OP_PUSH_FRONT) begin
          entry_model.insert(0, v);
        end else if (op == OP_PUSH_MIDDLE) begin
          entry_model.insert(n / 2, v);
        end else begin
          entry_model.insert(n, v);
        end
      end
      OP_POP_FRONT, OP_POP_MIDDLE, OP_POP_BACK: begin
        if (n == 0) begin
          r.pop_value = '1;
          r.status    = STAT_EMPTY;
        end else if (op == OP_POP_FRONT) begin
          r.pop_value = entry_model[0];
          entry_model.delete(0);
        end else if (op == OP_POP_MIDDLE) begin
          r.pop_value = entry_model[(n - 1) / 2];
          entry_model.delete((n - 1) / 2);
        end else begin
          r.pop_value = entry_model[n - 1];
          entry_model.delete(n - 1);
        end
      end
      default: ;  // unused codes leave the queue alone
    endcase
    r.occupancy = OCC_W'(entry_model.size());
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [VAL_W-1:0] expd,
                                 input logic [VAL_W-1:0] act);
    fail_count++;
    if (lines_printed < REPORT_CAP) begin
      $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h", $time, field, expd, act);
      lines_printed++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_model.delete();
      awaited_results.delete();
    end else begin
      // A result can never belong to a request taken at the same edge,
      // so compare first and predict afterwards.
      if (out_valid_i && !out_stall_i) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          fail_count++;
          if (lines_printed < REPORT_CAP) begin
            $display("%0t: result with no request waiting, expected none, actual 'h%0h",
                     $time, pop_value_i);
            lines_printed++;
          end
        end else begin
          oldest = awaited_results[0];
          awaited_results.delete(0);
          if (pop_value_i !== oldest.pop_value)
            report_mismatch("pop_value", oldest.pop_value, pop_value_i);
          if (status_i !== oldest.status)
            report_mismatch("status", VAL_W'(oldest.status), VAL_W'(status_i));
          if (occupancy_i !== oldest.occupancy)
            report_mismatch("occupancy", VAL_W'(oldest.occupancy), VAL_W'(occupancy_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_results.insert(awaited_results.size(), queue_apply(op_i, push_value_i));
      end
    end
    fail_count_o <= fail_count;
    results_o    <= results_seen;
    pending_o    <= awaited_results.size();
  end

endmodule

// File: dv/tb_top.sv
// Testbench top for the front/middle/back queue: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_top;
  import fmbq_pkg::*;

  // Random requests that touch the queue; unused codes come on top of this.
  localparam int RANDOM_ITEMS = 1650;
  // Long receiver hold-offs, keyed to the number of results taken so far.
  localparam int HOLD_AT_A  = 300;
  localparam int HOLD_AT_B  = 1100;
  localparam int HOLD_LONG  = 150;
  localparam int MAX_IDLE   = 19;
  // Drain time after the last result is taken, to catch any extra result.
  localparam int DRAIN_CYCLES = 10;

  localparam logic [OP_W-1:0]         OP_NOP_A = 3'd6;
  localparam logic [OP_W-1:0]         OP_NOP_B = 3'd7;
  localparam logic signed [VAL_W-1:0] VAL_MIN  = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX  = 32'sh7FFF_FFFF;

  // Mix of a burst of random requests: pushes, pops or an even split.
  typedef enum int { MIX_FILL, MIX_DRAIN, MIX_EVEN } mix_e;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_valid   = 1'b0;
  logic [OP_W-1:0]         op         = '0;
  logic signed [VAL_W-1:0] push_value = '0;
  logic                    out_stall  = 1'b0;

  wire                     in_stall;
  wire                     out_valid;
  wire signed [VAL_W-1:0]  pop_value;
  wire [STAT_W-1:0]        status;
  wire [OCC_W-1:0]         occupancy;

  int fail_count;
  int results_seen;
  int pending;
  int requests_sent = 0;
  bit sender_quiet  = 1'b0;  // burst with back-to-back requests

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  front_middle_back_queue_unit dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .op_i         (op),
    .push_value_i (push_value),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .pop_value_o  (pop_value),
    .status_o     (status),
    .occupancy_o  (occupancy)
  );

  fmbq_checker u_scoreboard (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .op_i         (op),
    .push_value_i (push_value),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .pop_value_i  (pop_value),
    .status_i     (status),
    .occupancy_i  (occupancy),
    .fail_count_o (fail_count),
    .results_o    (results_seen),
    .pending_o    (pending)
  );

  // Values lean on the sign boundaries, zero and all ones.
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Offers one request after a random gap and returns at the edge that
  // takes it. valid stays high across back-to-back requests, so it never
  // gets two assignments at one edge.
  task automatic send_request(input logic [OP_W-1:0] code,
                              input logic signed [VAL_W-1:0] value);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= code;
    push_value <= value;
    do @(posedge clk); while (!(in_valid && !in_stall));
    requests_sent++;
  endtask

  // Stimulus and verdict.
  initial begin
    mix_e            mix;
    int              burst_left;
    int              real_count;
    int              thresh;
    bit              pushing;
    logic [OP_W-1:0] code;

    burst_left = 0;
    real_count = 0;
    mix        = MIX_EVEN;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Pop of an empty queue, once per position.
    send_request(OP_POP_FRONT, VAL_MAX);
    send_request(OP_POP_MIDDLE, VAL_MIN);
    send_request(OP_POP_BACK, '0);

    // Fill to capacity, rotating through the three push positions.
    for (int i = 0; i < CAPACITY; i++) begin
      case (i % 3)
        0:       code = OP_PUSH_BACK;
        1:       code = OP_PUSH_FRONT;
        default: code = OP_PUSH_MIDDLE;
      endcase
      send_request(code, (i == 0) ? VAL_MIN : (i == 1) ? VAL_MAX : pick_value());
    end

    // Push on a full queue: dropped, flagged full.
    send_request(OP_PUSH_FRONT, '1);
    send_request(OP_PUSH_MIDDLE, VAL_MAX);
    send_request(OP_PUSH_BACK, VAL_MIN);

    // Unused codes are no-ops that still report occupancy.
    send_request(OP_NOP_A, '1);
    send_request(OP_NOP_B, '0);

    send_request(OP_POP_MIDDLE, '0);
    send_request(OP_POP_FRONT, '0);
    send_request(OP_POP_BACK, '0);

    // Random bursts that lean toward filling or draining, so the queue
    // swings between full and empty with every position used in between.
    while (real_count < RANDOM_ITEMS) begin
      if (burst_left == 0) begin
        burst_left   = $urandom_range(10, 50);
        mix          = mix_e'($urandom_range(0, 2));
        sender_quiet = ($urandom_range(0, 3) == 0);
      end
      burst_left--;
      if ($urandom_range(0, 99) < 3) begin
        code = $urandom_range(0, 1) ? OP_NOP_A : OP_NOP_B;
      end else begin
        thresh  = (mix == MIX_FILL) ? 80 : (mix == MIX_DRAIN) ? 20 : 50;
        pushing = ($urandom_range(0, 99) < thresh);
        case ($urandom_range(0, 2))
          0:       code = pushing ? OP_PUSH_FRONT : OP_POP_FRONT;
          1:       code = pushing ? OP_PUSH_MIDDLE : OP_POP_MIDDLE;
          default: code = pushing ? OP_PUSH_BACK : OP_POP_BACK;
        endcase
        real_count++;
      end
      send_request(code, pick_value());
    end
    in_valid <= 1'b0;

    // Every request yields one result; wait for all of them, then idle for
    // DRAIN_CYCLES to catch anything extra.
    while (results_seen < requests_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Receiver: random stall before each result, quiet stretches now and
  // then, and two long hold-offs that back the block up into its input.
  initial begin
    int hold;
    int taken;
    bit quiet;
    taken = 0;
    quiet = 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (taken % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (taken == HOLD_AT_A || taken == HOLD_AT_B) hold = HOLD_LONG;
      else hold = quiet ? 0 : $urandom_range(0, MAX_IDLE);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      taken++;
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
